FILE: hdl/pivr_pkg.sv
package pivr_pkg;

   localparam int SETPOINT_W = 16;
   localparam int GAIN_W     = 20;
   localparam int LIMIT_W    = 12;
   localparam int DUTY_W     = 12;
   localparam int ERR_W      = 18;
   localparam int INTEG_W    = 34;
   localparam int FRAC_OUT   = 20;
   localparam int PROD_SHIFT = 8;
   localparam int STEP_W     = 31;
   localparam int PROP_W     = 30;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MAX     = 3'd4;

   localparam logic [SETPOINT_W-1:0] SETPOINT_RST    = 16'd64225;
   localparam logic [GAIN_W-1:0]     PROP_GAIN_RST   = 20'd11744;
   localparam logic [GAIN_W-1:0]     INTEG_GAIN_RST  = 20'd839;
   localparam logic [LIMIT_W-1:0]    INTEG_LIMIT_RST = 12'd1500;
   localparam logic [LIMIT_W-1:0]    OUT_MAX_RST     = 12'd1500;

   typedef struct packed {
      logic [SETPOINT_W-1:0] setpoint;
      logic [GAIN_W-1:0]     prop_gain;
      logic [GAIN_W-1:0]     integ_gain;
      logic [LIMIT_W-1:0]    integ_limit;
      logic [LIMIT_W-1:0]    out_max;
   } cfg_type;

   typedef struct packed {
      logic signed [STEP_W-1:0] integ_step;
      logic signed [PROP_W-1:0] prop;
   } prod_type;

endpackage

FILE: hdl/pivr_csr.sv
module pivr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pivr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pivr_pkg::CSR_DATA_W-1:0]  csr_data,
   output pivr_pkg::cfg_type                cfg
);

   pivr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pivr_pkg::REG_SETPOINT:
               cfg_in.setpoint = csr_data[pivr_pkg::SETPOINT_W-1:0];
            pivr_pkg::REG_PROP_GAIN:
               cfg_in.prop_gain = csr_data[pivr_pkg::GAIN_W-1:0];
            pivr_pkg::REG_INTEG_GAIN:
               cfg_in.integ_gain = csr_data[pivr_pkg::GAIN_W-1:0];
            pivr_pkg::REG_INTEG_LIMIT:
               cfg_in.integ_limit = csr_data[pivr_pkg::LIMIT_W-1:0];
            pivr_pkg::REG_OUT_MAX:
               cfg_in.out_max = csr_data[pivr_pkg::LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint    <= pivr_pkg::SETPOINT_RST;
         cfg_ff.prop_gain   <= pivr_pkg::PROP_GAIN_RST;
         cfg_ff.integ_gain  <= pivr_pkg::INTEG_GAIN_RST;
         cfg_ff.integ_limit <= pivr_pkg::INTEG_LIMIT_RST;
         cfg_ff.out_max     <= pivr_pkg::OUT_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

FILE: hdl/pivr_mul_stage.sv
module pivr_mul_stage #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pivr_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pivr_pkg::prod_type     prod
);

   localparam int Q4_W   = 16;
   localparam int PAIR_W = pivr_pkg::ERR_W + 1;
   localparam int GS_W   = pivr_pkg::GAIN_W + 1;
   localparam int PI_W   = PAIR_W + GS_W;
   localparam int PP_W   = pivr_pkg::ERR_W + GS_W;

   logic                               valid_ff, valid_in;
   logic                               load;
   logic signed [pivr_pkg::ERR_W-1:0]  prev_err_ff;
   pivr_pkg::prod_type                 prod_ff;
   logic [Q4_W-1:0]                    sample_q4;
   logic signed [pivr_pkg::ERR_W-1:0]  err;
   logic signed [PAIR_W-1:0]           pair;
   logic signed [GS_W-1:0]             ki_s, kp_s;
   logic signed [PI_W-1:0]             prod_i;
   logic signed [PP_W-1:0]             prod_p;

   // sample taken as a fraction of 12-bit full scale, Q.4
   assign sample_q4 = Q4_W'(sample) << (Q4_W - SAMPLE_BITS);
   assign err  = $signed({2'b00, cfg.setpoint}) - $signed({2'b00, sample_q4});
   assign pair = PAIR_W'(err) + PAIR_W'(prev_err_ff);
   assign ki_s = $signed({1'b0, cfg.integ_gain});
   assign kp_s = $signed({1'b0, cfg.prop_gain});
   assign prod_i = PI_W'(pair) * PI_W'(ki_s);
   assign prod_p = PP_W'(err) * PP_W'(kp_s);

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         prev_err_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            prev_err_ff <= err;
         end
      end
   end

   // floor shift by PROD_SHIFT
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff.integ_step <=
            prod_i[pivr_pkg::STEP_W+pivr_pkg::PROD_SHIFT-1:pivr_pkg::PROD_SHIFT];
         prod_ff.prop <=
            prod_p[pivr_pkg::PROP_W+pivr_pkg::PROD_SHIFT-1:pivr_pkg::PROD_SHIFT];
      end
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;

endmodule

FILE: hdl/pivr_integ_stage.sv
module pivr_integ_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  pivr_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  pivr_pkg::prod_type            prod,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [pivr_pkg::DUTY_W-1:0]   duty_compare,
   output logic                          saturated
);

   localparam int SUM_W = pivr_pkg::INTEG_W + 1;
   localparam logic signed [pivr_pkg::INTEG_W-1:0] INTEG_BOUND =
      pivr_pkg::INTEG_W'(4095) <<< pivr_pkg::FRAC_OUT;

   logic                                 valid_ff, valid_in;
   logic                                 load;
   logic signed [pivr_pkg::INTEG_W-1:0]  integ_ff, integ_in;
   logic [pivr_pkg::DUTY_W-1:0]          duty_ff, duty_in;
   logic                                 sat_ff, sat_in;
   logic signed [SUM_W-1:0]              integ_sum, lim, neg_lim, top, sum;

   always_comb begin
      lim       = $signed({3'b000, cfg.integ_limit, {pivr_pkg::FRAC_OUT{1'b0}}});
      neg_lim   = -lim;
      top       = $signed({3'b000, cfg.out_max, {pivr_pkg::FRAC_OUT{1'b0}}});
      integ_sum = SUM_W'(integ_ff) + SUM_W'(prod.integ_step);
      if (integ_sum > lim) begin
         integ_in = lim[pivr_pkg::INTEG_W-1:0];
      end else if (integ_sum < neg_lim) begin
         integ_in = neg_lim[pivr_pkg::INTEG_W-1:0];
      end else begin
         integ_in = integ_sum[pivr_pkg::INTEG_W-1:0];
      end
      sum = SUM_W'(integ_in) + SUM_W'(prod.prop);
      if (sum >= top) begin
         duty_in = cfg.out_max;
         sat_in  = 1'b1;
      end else if (sum <= 0) begin
         duty_in = '0;
         sat_in  = 1'b1;
      end else begin
         duty_in = sum[pivr_pkg::FRAC_OUT+pivr_pkg::DUTY_W-1:pivr_pkg::FRAC_OUT];
         sat_in  = 1'b0;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         integ_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         duty_ff <= duty_in;
         sat_ff  <= sat_in;
      end
   end

   assign out_valid    = valid_ff;
   assign duty_compare = duty_ff;
   assign saturated    = sat_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !valid_ff)
      else $error("result register valid after reset");

   a_integ_hold: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(integ_ff))
      else $error("integrator changed without an item");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded item not presented");

   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= INTEG_BOUND) && (integ_ff >= -INTEG_BOUND))
      else $error("integrator beyond largest limit");

endmodule

FILE: hdl/pi_voltage_regulator.sv
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  tdata: sample
// rsp      out        rsp_tvalid/rsp_tready  tdata: duty_compare; tuser: saturated
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// Three register stages: input, error/products, integrator/clamp result.
// One item per cycle unless rsp stalls; rsp_tvalid comes from the result register.
// Integrator add and clamp form a single combinational loop, which sets the item rate.
// Synchronous reset clears the integrator, previous error and valid flags.
// Each stage holds its item under rsp stall; bubbles are still filled.
module pi_voltage_regulator #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,   // [SAMPLE_BITS-1:0] sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,   // [11:0] duty_compare
   output logic                                 rsp_tuser,   // [0] saturated
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pivr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pivr_pkg::CSR_DATA_W-1:0]      csr_data
);

   pivr_pkg::cfg_type               cfg;
   pivr_pkg::prod_type              prod;
   logic                            in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0]          sample_ff;
   logic                            load;
   logic                            mul_ready, mul_valid, integ_ready;
   logic [pivr_pkg::DUTY_W-1:0]     duty;

   pivr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req_tready  = !in_valid_ff || mul_ready;
   assign load        = req_tvalid && req_tready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
   end

   pivr_mul_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_ready  (mul_ready),
      .sample    (sample_ff),
      .out_valid (mul_valid),
      .out_ready (integ_ready),
      .prod      (prod)
   );

   pivr_integ_stage u_integ (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (mul_valid),
      .in_ready     (integ_ready),
      .prod         (prod),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .duty_compare (duty),
      .saturated    (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, duty};

endmodule

FILE: test/tb_pi_voltage_regulator.sv
`timescale 1ns / 1ps

module tb_pi_voltage_regulator;

   localparam int SMP_W   = 12;
   localparam int REQ_W   = ((SMP_W + 7) / 8) * 8;
   localparam int SMP_MAX = (1 << SMP_W) - 1;

   localparam logic [pivr_pkg::CSR_DATA_W-1:0] SETPOINT_TOP =
      pivr_pkg::CSR_DATA_W'((1 << pivr_pkg::SETPOINT_W) - 1);
   localparam logic [pivr_pkg::CSR_DATA_W-1:0] GAIN_TOP =
      pivr_pkg::CSR_DATA_W'((1 << pivr_pkg::GAIN_W) - 1);
   localparam logic [pivr_pkg::CSR_DATA_W-1:0] LIMIT_TOP =
      pivr_pkg::CSR_DATA_W'((1 << pivr_pkg::LIMIT_W) - 1);

   typedef struct {
      logic [pivr_pkg::DUTY_W-1:0] duty;
      logic                        sat;
   } drive_type;

   class duty_predictor_type;
      pivr_pkg::cfg_type                   cfg;
      logic signed [pivr_pkg::ERR_W-1:0]   last_err;
      logic signed [pivr_pkg::INTEG_W-1:0] integ_acc;
      drive_type                           duty_expected[$];
      int unsigned                         errors;

      function new();
         cfg.setpoint    = pivr_pkg::SETPOINT_RST;
         cfg.prop_gain   = pivr_pkg::PROP_GAIN_RST;
         cfg.integ_gain  = pivr_pkg::INTEG_GAIN_RST;
         cfg.integ_limit = pivr_pkg::INTEG_LIMIT_RST;
         cfg.out_max     = pivr_pkg::OUT_MAX_RST;
         last_err  = '0;
         integ_acc = '0;
         errors    = 0;
      endfunction

      function void set_reg(logic [pivr_pkg::CSR_IDX_W-1:0] idx,
                            logic [pivr_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            pivr_pkg::REG_SETPOINT:
               cfg.setpoint    = val[pivr_pkg::SETPOINT_W-1:0];
            pivr_pkg::REG_PROP_GAIN:
               cfg.prop_gain   = val[pivr_pkg::GAIN_W-1:0];
            pivr_pkg::REG_INTEG_GAIN:
               cfg.integ_gain  = val[pivr_pkg::GAIN_W-1:0];
            pivr_pkg::REG_INTEG_LIMIT:
               cfg.integ_limit = val[pivr_pkg::LIMIT_W-1:0];
            pivr_pkg::REG_OUT_MAX:
               cfg.out_max     = val[pivr_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SMP_W-1:0] smp);
         longint err, pair, lim, top, integ, prop, total;
         drive_type d;
         err   = longint'(cfg.setpoint) - (longint'(smp) << 4);
         pair  = err + longint'(last_err);
         lim   = longint'(cfg.integ_limit) << pivr_pkg::FRAC_OUT;
         top   = longint'(cfg.out_max) << pivr_pkg::FRAC_OUT;
         integ = longint'(integ_acc) +
                 ((pair * longint'(cfg.integ_gain)) >>> pivr_pkg::PROD_SHIFT);
         if (integ > lim)
            integ = lim;
         else if (integ < -lim)
            integ = -lim;
         integ_acc = integ[pivr_pkg::INTEG_W-1:0];
         last_err  = err[pivr_pkg::ERR_W-1:0];
         prop  = (err * longint'(cfg.prop_gain)) >>> pivr_pkg::PROD_SHIFT;
         total = integ + prop;
         if (total >= top) begin
            d.duty = cfg.out_max;
            d.sat  = 1'b1;
         end else if (total <= 0) begin
            d.duty = '0;
            d.sat  = 1'b1;
         end else begin
            d.duty = total[pivr_pkg::FRAC_OUT+pivr_pkg::DUTY_W-1:pivr_pkg::FRAC_OUT];
            d.sat  = 1'b0;
         end
         duty_expected.push_back(d);
      endfunction

      function void check_drive(logic [pivr_pkg::DUTY_W-1:0] duty, logic sat);
         drive_type want;
         if (duty_expected.size() == 0) begin
            $error("drive item with none pending: duty_compare %0d saturated %0b",
                   duty, sat);
            errors++;
            return;
         end
         want = duty_expected.pop_front();
         if (duty !== want.duty) begin
            $error("duty_compare: expected %0d, got %0d", want.duty, duty);
            errors++;
         end
         if (sat !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, sat);
            errors++;
         end
      endfunction

      function int pending();
         return duty_expected.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [REQ_W-1:0]                req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [15:0]                     rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [pivr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pivr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   duty_predictor_type pred = new();
   bit                 steady = 1'b0;
   int                 rsp_hold = 0;

   pi_voltage_regulator #(.SAMPLE_BITS(SMP_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic logic [pivr_pkg::CSR_DATA_W-1:0] pick_reg(
      logic [pivr_pkg::CSR_DATA_W-1:0] hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      else if (r == 1)
         return hi;
      else
         return pivr_pkg::CSR_DATA_W'($urandom_range(0, hi));
   endfunction

   function automatic logic [SMP_W-1:0] pick_sample();
      int r, c;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         c = int'(pred.cfg.setpoint >> 4) + int'($urandom_range(0, 128)) - 64;
         if (c < 0)
            c = 0;
         else if (c > SMP_MAX)
            c = SMP_MAX;
         return SMP_W'(c);
      end else if (r < 85)
         return SMP_W'($urandom_range(0, SMP_MAX));
      else if (r < 93)
         return '0;
      else
         return SMP_W'(SMP_MAX);
   endfunction

   // entered and left just after a falling edge
   task automatic send_sample(logic [SMP_W-1:0] smp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_W-SMP_W){1'b0}}, smp};
      do @(posedge clock); while (!req_tready);
      pred.note_sample(smp);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [pivr_pkg::CSR_IDX_W-1:0] idx,
                            logic [pivr_pkg::CSR_DATA_W-1:0] val);
      req_tvalid = 1'b0;
      csr_valid  = 1'b1;
      csr_index  = idx;
      csr_data   = val;
      do @(posedge clock); while (!csr_ready);
      pred.set_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_tvalid = 1'b0;
      while (pred.pending() != 0 && n < 50000) begin
         @(negedge clock);
         n++;
      end
   endtask

   initial begin
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_tready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready = 1'b1;
            rsp_hold   = pick_gap();
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            pred.check_drive(rsp_tdata[pivr_pkg::DUTY_W-1:0], rsp_tuser);
         @(negedge clock);
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // reset settings: extremes, on and around the setpoint
      send_sample('0);
      send_sample(SMP_W'(SMP_MAX));
      send_sample('0);
      send_sample(SMP_W'(SMP_MAX));
      send_sample(SMP_W'(pivr_pkg::SETPOINT_RST >> 4));
      send_sample(SMP_W'(pivr_pkg::SETPOINT_RST >> 4));
      send_sample(SMP_W'((pivr_pkg::SETPOINT_RST >> 4) - 1));
      send_sample(SMP_W'((pivr_pkg::SETPOINT_RST >> 4) + 1));
      send_sample(12'h555);
      send_sample(12'hAAA);
      send_sample(12'h800);
      send_sample(12'h001);
      drain();

      // zero limits hold integrator and output at zero
      write_reg(pivr_pkg::REG_SETPOINT, SETPOINT_TOP);
      write_reg(pivr_pkg::REG_PROP_GAIN, GAIN_TOP);
      write_reg(pivr_pkg::REG_INTEG_GAIN, GAIN_TOP);
      write_reg(pivr_pkg::REG_INTEG_LIMIT, '0);
      write_reg(pivr_pkg::REG_OUT_MAX, '0);
      write_reg(pivr_pkg::REG_OUT_MAX + 3'd1, '1);
      write_reg(pivr_pkg::REG_OUT_MAX + 3'd3, '0);
      send_sample('0);
      send_sample(SMP_W'(SMP_MAX));
      send_sample(12'h7D0);
      send_sample('0);
      drain();

      // zero setpoint, full gains and limits: deep negative error
      write_reg(pivr_pkg::REG_SETPOINT, '0);
      write_reg(pivr_pkg::REG_INTEG_LIMIT, LIMIT_TOP);
      write_reg(pivr_pkg::REG_OUT_MAX, LIMIT_TOP);
      send_sample(SMP_W'(SMP_MAX));
      send_sample(SMP_W'(SMP_MAX));
      send_sample('0);
      send_sample('0);
      drain();
      write_reg(pivr_pkg::REG_SETPOINT, SETPOINT_TOP);
      send_sample('0);
      send_sample('0);
      drain();

      for (int p = 0; p < 10; p++) begin
         steady = ($urandom_range(0, 3) == 0);
         write_reg(pivr_pkg::REG_SETPOINT, pick_reg(SETPOINT_TOP));
         write_reg(pivr_pkg::REG_PROP_GAIN, pick_reg(GAIN_TOP));
         write_reg(pivr_pkg::REG_INTEG_GAIN, pick_reg(GAIN_TOP));
         write_reg(pivr_pkg::REG_INTEG_LIMIT, pick_reg(LIMIT_TOP));
         write_reg(pivr_pkg::REG_OUT_MAX, pick_reg(LIMIT_TOP));
         if ($urandom_range(0, 2) == 0)
            write_reg(pivr_pkg::CSR_IDX_W'(pivr_pkg::REG_OUT_MAX + 1 +
                                          $urandom_range(0, 2)),
                      pivr_pkg::CSR_DATA_W'($urandom));
         repeat (125) send_sample(pick_sample());
         drain();
      end

      repeat (6) @(negedge clock);
      if (pred.pending() != 0)
         $error("%0d drive items never arrived", pred.pending());
      if (pred.errors == 0 && pred.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/pivr_pkg.sv
hdl/pivr_csr.sv
hdl/pivr_mul_stage.sv
hdl/pivr_integ_stage.sv
hdl/pi_voltage_regulator.sv
test/tb_pi_voltage_regulator.sv
